[hw/rtl/pims_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pims_pkg
// Shared types and constants of the parallel i2c master sequencer.
// ----------------------------------------------------------------------------
package pims_pkg;

    // command codes carried in the mode field
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam int SDA_PORTS      = 4;   // ports sampled on the sda_in field
    localparam int RD_PORTS       = 4;   // ports reported on the result
    localparam int DEF_PORT_COUNT = 4;
    localparam int MAX_SEND_BYTES = 4;
    localparam int ADDR_BYTES     = 2;   // device address byte, register byte
    localparam int MAX_WR_DATA    = (MAX_SEND_BYTES - ADDR_BYTES) < 2 ?
                                    (MAX_SEND_BYTES - ADDR_BYTES) : 2;
    localparam int MAX_RD_DATA    = 4;
    localparam int SEND_DEPTH     = 4;

    localparam logic [4:0] STEP_DATA_END = 5'd16;  // first step after eight bits
    localparam logic [4:0] STEP_ACK_HIGH = 5'd17;
    localparam logic [4:0] STEP_ACK_DONE = 5'd18;
    localparam logic [7:0] READ_FLAG     = 8'h01;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_WRITE = 3'd2,
        PH_READ  = 3'd3,
        PH_END   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [2:0] length;
        logic [7:0] write_data_0;
        logic [7:0] write_data_1;
        logic [3:0] sda_in;
    } t_cmd;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       accepted;
        logic       byte_valid;
        logic [1:0] byte_index;
        logic [7:0] read_byte_0;
        logic [7:0] read_byte_1;
        logic [7:0] read_byte_2;
        logic [7:0] read_byte_3;
    } t_res;

    // status of one step, from the sequencer to the result register
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       accepted;
        logic       byte_valid;
        logic [1:0] byte_index;
    } t_seq_stat;

endpackage

[hw/rtl/pims_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pims_cmd_if / pims_res_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface pims_cmd_if;
    import pims_pkg::*;
    logic valid;
    logic ready;
    t_cmd payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pims_res_if;
    import pims_pkg::*;
    logic valid;
    logic ready;
    t_res payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/pims_shift.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pims_shift
// Per-port receive shift registers, all clocked in lockstep.
// ----------------------------------------------------------------------------
module pims_shift #(
    parameter int PORT_COUNT = pims_pkg::DEF_PORT_COUNT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_shift_en,
    input  logic [pims_pkg::SDA_PORTS-1:0]         i_sda,
    output logic [pims_pkg::RD_PORTS-1:0][7:0]     o_bytes
);
    import pims_pkg::*;

    // ports past the sampled field only ever shift in zero, so they are not stored
    localparam int LANES = PORT_COUNT < SDA_PORTS ? PORT_COUNT : SDA_PORTS;

    logic [LANES-1:0][7:0] r_shift;
    logic [LANES-1:0][7:0] n_shift;

    always_comb begin
        n_shift = r_shift;
        if (i_shift_en) begin
            for (int k = 0; k < LANES; k++) begin
                n_shift[k] = {r_shift[k][6:0], i_sda[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
        end else begin
            r_shift <= n_shift;
        end
    end

    for (genvar k = 0; k < RD_PORTS; k++) begin : g_out
        if (k < LANES) begin : g_lane
            assign o_bytes[k] = r_shift[k];
        end else begin : g_none
            assign o_bytes[k] = 8'd0;
        end
    end

endmodule

[hw/rtl/pims_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pims_ctrl
// Phase sequencer: start, byte send, byte receive and stop half-bit steps.
// ----------------------------------------------------------------------------
module pims_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  pims_pkg::t_cmd      i_cmd,
    output logic                o_shift_en,
    output pims_pkg::t_seq_stat o_stat
);
    import pims_pkg::*;

    t_phase     r_phase, n_phase;
    logic [4:0] r_step, n_step;
    logic [2:0] r_send_off, n_send_off;
    logic [2:0] r_send_tot, n_send_tot;
    logic [2:0] r_recv_off, n_recv_off;
    logic [2:0] r_recv_tot, n_recv_tot;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic [7:0] r_send_bytes [SEND_DEPTH];

    logic       tick;
    logic       load;
    logic       wrap;
    logic       is_send;
    logic       ack;
    logic [7:0] tx_byte;
    logic       tx_bit;
    logic [2:0] wr_count;
    logic [2:0] rd_count;
    logic [2:0] send_off_inc;
    logic [2:0] recv_off_inc;
    logic       byte_valid;

    assign tick  = i_step && (i_cmd.mode == MODE_TICK);
    assign load  = i_step && (r_phase == PH_IDLE)
                   && (i_cmd.mode == MODE_WRITE || i_cmd.mode == MODE_READ);
    assign wrap  = r_step > STEP_ACK_DONE;
    assign is_send = (r_phase == PH_WRITE) || (r_recv_off == 3'd0);
    assign ack   = r_recv_off < r_recv_tot;
    assign tx_byte = (r_phase == PH_WRITE) ? r_send_bytes[r_send_off[1:0]]
                                           : (r_send_bytes[0] | READ_FLAG);
    // msb first
    assign tx_bit = tx_byte[~r_step[3:1]];
    assign send_off_inc = r_send_off + 3'd1;
    assign recv_off_inc = r_recv_off + 3'd1;

    assign wr_count = (i_cmd.length > 3'(MAX_WR_DATA)) ? 3'(MAX_WR_DATA) : i_cmd.length;
    assign rd_count = (i_cmd.length > 3'(MAX_RD_DATA)) ? 3'(MAX_RD_DATA) : i_cmd.length;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (load) begin
            n_phase = PH_START;
        end else if (tick) begin
            unique case (r_phase)
                PH_START: begin
                    if (r_step != 5'd0) begin
                        if (r_send_off < r_send_tot) begin
                            n_phase = PH_WRITE;
                        end else if (r_recv_tot != 3'd0) begin
                            n_phase = PH_READ;
                        end else begin
                            n_phase = PH_END;
                        end
                    end
                end
                PH_WRITE: begin
                    if (wrap && send_off_inc >= r_send_tot) begin
                        n_phase = PH_END;
                    end
                end
                PH_READ: begin
                    if (wrap && recv_off_inc > r_recv_tot) begin
                        n_phase = PH_END;
                    end
                end
                PH_END: begin
                    if (r_step != 5'd0) begin
                        if (r_recv_tot != 3'd0 && r_recv_off <= r_recv_tot) begin
                            n_phase = PH_START;   // restart for the read half
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // step counter, offsets and line levels
    always_comb begin
        n_step     = r_step;
        n_send_off = r_send_off;
        n_send_tot = r_send_tot;
        n_recv_off = r_recv_off;
        n_recv_tot = r_recv_tot;
        n_scl      = r_scl;
        n_sda      = r_sda;
        o_shift_en = 1'b0;
        byte_valid = 1'b0;
        if (load) begin
            n_step     = 5'd0;
            n_send_off = 3'd0;
            n_recv_off = 3'd0;
            if (i_cmd.mode == MODE_WRITE) begin
                n_send_tot = 3'(ADDR_BYTES) + wr_count;
                n_recv_tot = 3'd0;
            end else begin
                n_send_tot = 3'(ADDR_BYTES);
                n_recv_tot = rd_count;
            end
        end else if (tick) begin
            unique case (r_phase)
                PH_START: begin
                    if (r_step == 5'd0) begin
                        n_sda  = 1'b0;
                        n_step = 5'd1;
                    end else begin
                        n_scl  = 1'b0;
                        n_step = 5'd0;
                    end
                end
                PH_WRITE, PH_READ: begin
                    if (r_step < STEP_DATA_END) begin
                        if (!r_step[0]) begin
                            if (is_send) begin
                                n_scl = 1'b0;
                                n_sda = tx_bit;
                            end else begin
                                n_sda = 1'b1;
                                n_scl = 1'b1;
                            end
                        end else begin
                            n_scl      = is_send;
                            o_shift_en = !is_send;
                        end
                        n_step = r_step + 5'd1;
                    end else if (r_step == STEP_DATA_END) begin
                        if (is_send) begin
                            n_scl = 1'b0;
                            n_sda = 1'b1;
                        end else begin
                            n_sda = !ack;
                        end
                        n_step = r_step + 5'd1;
                    end else if (r_step == STEP_ACK_HIGH) begin
                        n_scl  = 1'b1;
                        n_step = r_step + 5'd1;
                    end else if (r_step == STEP_ACK_DONE) begin
                        n_scl  = 1'b0;
                        n_step = r_step + 5'd1;
                    end else begin
                        // after a nack the master pulls sda low so a stop follows
                        n_sda  = is_send ? 1'b0 : ack;
                        n_step = 5'd0;
                        if (r_phase == PH_WRITE) begin
                            n_send_off = send_off_inc;
                        end else begin
                            byte_valid = r_recv_off != 3'd0;
                            n_recv_off = recv_off_inc;
                        end
                    end
                end
                PH_END: begin
                    if (r_step == 5'd0) begin
                        n_scl  = 1'b1;
                        n_step = 5'd1;
                    end else begin
                        n_sda  = 1'b1;
                        n_step = 5'd0;
                    end
                end
                default: begin
                    n_step = r_step;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.scl        = n_scl;
        o_stat.sda        = n_sda;
        o_stat.busy       = n_phase != PH_IDLE;
        o_stat.accepted   = load;
        o_stat.byte_valid = byte_valid;
        o_stat.byte_index = byte_valid ? 2'(r_recv_off - 3'd1) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_step     <= 5'd0;
            r_send_off <= 3'd0;
            r_send_tot <= 3'd0;
            r_recv_off <= 3'd0;
            r_recv_tot <= 3'd0;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
        end else begin
            r_phase    <= n_phase;
            r_step     <= n_step;
            r_send_off <= n_send_off;
            r_send_tot <= n_send_tot;
            r_recv_off <= n_recv_off;
            r_recv_tot <= n_recv_tot;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
        end
    end

    // send buffer: address with write flag, register, then data
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_send_bytes[0] <= {i_cmd.dev_addr, 1'b0};
            r_send_bytes[1] <= i_cmd.reg_addr;
            if (i_cmd.mode == MODE_WRITE && wr_count > 3'd0) begin
                r_send_bytes[2] <= i_cmd.write_data_0;
            end
            if (i_cmd.mode == MODE_WRITE && wr_count > 3'd1) begin
                r_send_bytes[3] <= i_cmd.write_data_1;
            end
        end
    end

endmodule

[hw/rtl/parallel_i2c_master_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_i2c_master_sequencer
// I2C master that drives one SCL/SDA pattern to several ports in lockstep.
// ----------------------------------------------------------------------------
// Every command beat gives exactly one result beat. A tick beat advances the
// bus by one half-bit phase; a write or read command beat is taken only when
// the sequencer is idle (accepted shows it) and takes no tick itself. Each beat
// is handled by the combinational sequencer logic and lands in a result
// register, so one beat is taken per clock while the command side is ready
// and its result appears on the next cycle; the command side stays ready as
// long as the result register is empty or being drained. Received bytes of
// all ports come out together with byte_valid and their position in the read.
module parallel_i2c_master_sequencer #(
    parameter int PORT_COUNT = pims_pkg::DEF_PORT_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pims_cmd_if.sink           i_cmd,
    pims_res_if.source         o_res
);
    import pims_pkg::*;

    logic                       accept;
    logic                       shift_en;
    t_seq_stat                  stat;
    logic [RD_PORTS-1:0][7:0]   rx_bytes;
    logic                       r_valid, n_valid;
    t_res                       r_res, n_res;

    assign i_cmd.ready = !r_valid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    pims_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (accept),
        .i_cmd      (i_cmd.payload),
        .o_shift_en (shift_en),
        .o_stat     (stat)
    );

    pims_shift #(
        .PORT_COUNT (PORT_COUNT)
    ) u_shift (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_shift_en (shift_en),
        .i_sda      (i_cmd.payload.sda_in),
        .o_bytes    (rx_bytes)
    );

    always_comb begin
        n_valid = r_valid;
        n_res   = r_res;
        if (accept) begin
            n_valid            = 1'b1;
            n_res.scl_out      = stat.scl;
            n_res.sda_out      = stat.sda;
            n_res.busy_res     = stat.busy;
            n_res.accepted     = stat.accepted;
            n_res.byte_valid   = stat.byte_valid;
            n_res.byte_index   = stat.byte_index;
            n_res.read_byte_0  = stat.byte_valid ? rx_bytes[0] : 8'd0;
            n_res.read_byte_1  = stat.byte_valid ? rx_bytes[1] : 8'd0;
            n_res.read_byte_2  = stat.byte_valid ? rx_bytes[2] : 8'd0;
            n_res.read_byte_3  = stat.byte_valid ? rx_bytes[3] : 8'd0;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res.valid   = r_valid;
    assign o_res.payload = r_res;

endmodule
